>>> hw/rtl/dtlv_pkg.sv
package dtlv_pkg;

  // Longest long-form length field, in bytes
  localparam int unsigned MaxLengthBytes = 7;

  // Width of the length-byte counter, sized to hold MaxLengthBytes
  localparam int unsigned LenCntW = $clog2(MaxLengthBytes + 1);

  // Width of a decoded element length
  localparam int unsigned LenW = 56;

  // Byte roles
  localparam logic [1:0] ROLE_TAG  = 2'd0;
  localparam logic [1:0] ROLE_LEN  = 2'd1;
  localparam logic [1:0] ROLE_VAL  = 2'd2;
  localparam logic [1:0] ROLE_NONE = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ZERO_TAG = 3'd1;
  localparam logic [2:0] ST_LEN_LONG = 3'd2;
  localparam logic [2:0] ST_TRUNC    = 3'd3;
  localparam logic [2:0] ST_HALTED   = 3'd4;

  // Input kind codes
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_EOS  = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } dtlv_in_t;

  typedef struct packed {
    logic [1:0]      byte_role;
    logic [7:0]      byte_out;
    logic [7:0]      element_tag;
    logic [LenW-1:0] element_length;
    logic            element_done;
    logic [2:0]      status;
  } dtlv_out_t;

endpackage

>>> hw/rtl/der_tlv_stream_parser.sv
// Byte-serial TLV splitter for a stream of back-to-back tag/length/value elements.
// Input channel: in_valid_i, in_stall_o, in_req_i (kind, data_byte). One request is
// one stream byte or an end-of-stream marker.
// Output channel: out_valid_o, out_stall_i, out_req_o. Every input request yields
// exactly one output request giving the byte's role, the current tag, the decoded
// length so far, an element-complete flag and a status code.
// The result is registered, valid in the cycle after acceptance. Throughput: one
// request per cycle unless stalled; the parser state and the result register both
// update in the cycle a byte is taken, so there is no loop beyond the state update.
// When the receiver stalls, the held result stays in the output register and the
// input is stalled only while that register is full and not being drained.
// Reset clears the parser to expect a tag, with tag, length and counters at zero,
// and empties the output register.
// A zero tag, an over-long length field or an end marker inside an element reports
// an error once; after that every request reports the halted status until reset.
module der_tlv_stream_parser
  import dtlv_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  dtlv_in_t  in_req_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output dtlv_out_t out_req_o
);

  // Parser phases
  localparam logic [1:0] PH_TAG  = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_LENX = 2'd2;
  localparam logic [1:0] PH_VAL  = 2'd3;

  logic [1:0]         phase_q, phase_d;
  logic [7:0]         tag_q, tag_d;
  logic [LenW-1:0]    acc_q, acc_d;
  logic [LenCntW-1:0] len_left_q, len_left_d;
  logic [LenW-1:0]    val_left_q, val_left_d;
  logic               halted_q, halted_d;

  logic      out_valid_q;
  dtlv_out_t out_req_q, res;
  logic      in_accept;
  logic [6:0] n_len;

  // Stall input only while a result waits and is not taken
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign n_len      = in_req_i.data_byte[6:0];

  // Next parser state and result for the offered byte
  always_comb begin
    phase_d    = phase_q;
    tag_d      = tag_q;
    acc_d      = acc_q;
    len_left_d = len_left_q;
    val_left_d = val_left_q;
    halted_d   = halted_q;

    res.byte_role    = ROLE_NONE;
    res.byte_out     = 8'd0;
    res.element_done = 1'b0;
    res.status       = ST_OK;

    if (halted_q) begin
      res.status = ST_HALTED;
    end else if (in_req_i.kind == KIND_EOS) begin
      if (phase_q != PH_TAG) begin
        res.status = ST_TRUNC;
        halted_d   = 1'b1;
      end
    end else begin
      res.byte_out = in_req_i.data_byte;
      unique case (phase_q)
        PH_TAG: begin
          res.byte_role = ROLE_TAG;
          tag_d         = in_req_i.data_byte;
          acc_d         = '0;
          if (in_req_i.data_byte == 8'd0) begin
            res.status = ST_ZERO_TAG;
            halted_d   = 1'b1;
          end else begin
            phase_d = PH_LEN;
          end
        end
        PH_LEN: begin
          res.byte_role = ROLE_LEN;
          if (in_req_i.data_byte[7]) begin
            if (n_len > 7'(MaxLengthBytes)) begin
              res.status = ST_LEN_LONG;
              halted_d   = 1'b1;
            end else if (n_len == 7'd0) begin
              // long form with no length bytes: empty element
              acc_d            = '0;
              res.element_done = 1'b1;
              phase_d          = PH_TAG;
            end else begin
              acc_d      = '0;
              len_left_d = n_len[LenCntW-1:0];
              phase_d    = PH_LENX;
            end
          end else begin
            acc_d = LenW'(n_len);
            if (n_len == 7'd0) begin
              res.element_done = 1'b1;
              phase_d          = PH_TAG;
            end else begin
              val_left_d = LenW'(n_len);
              phase_d    = PH_VAL;
            end
          end
        end
        PH_LENX: begin
          res.byte_role = ROLE_LEN;
          acc_d         = {acc_q[LenW-9:0], in_req_i.data_byte};
          len_left_d    = len_left_q - LenCntW'(1);
          if (len_left_q == LenCntW'(1)) begin
            if (acc_d == '0) begin
              res.element_done = 1'b1;
              phase_d          = PH_TAG;
            end else begin
              val_left_d = acc_d;
              phase_d    = PH_VAL;
            end
          end
        end
        PH_VAL: begin
          res.byte_role = ROLE_VAL;
          val_left_d    = val_left_q - LenW'(1);
          if (val_left_q == LenW'(1)) begin
            res.element_done = 1'b1;
            phase_d          = PH_TAG;
          end
        end
        default: begin
          phase_d = PH_TAG;
        end
      endcase
    end

    res.element_tag    = tag_d;
    res.element_length = acc_d;
  end

  // Advance parser state on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_TAG;
      tag_q      <= 8'd0;
      acc_q      <= '0;
      len_left_q <= '0;
      val_left_q <= '0;
      halted_q   <= 1'b0;
    end else if (in_accept) begin
      phase_q    <= phase_d;
      tag_q      <= tag_d;
      acc_q      <= acc_d;
      len_left_q <= len_left_d;
      val_left_q <= val_left_d;
      halted_q   <= halted_d;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_req_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

  // A completed element never carries an error
  a_done_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_req_o.element_done) |-> (out_req_o.status == ST_OK))
    else $error("element_done with error status");

  // Halt is sticky until reset
  a_halt_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halted state cleared without reset");

  // Long-form phase always has length bytes pending
  a_lenx_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_LENX) |-> (len_left_q != '0))
    else $error("long-form length phase with zero bytes left");

  // An unconsumed request passes no byte and completes nothing
  a_none_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_req_o.byte_role == ROLE_NONE)
      |-> (out_req_o.byte_out == 8'd0 && !out_req_o.element_done))
    else $error("unconsumed request carries data");

endmodule
